[design/one_shot_repeat_timer_table_macros.svh]
// assertion macros for the timer table checker
`ifndef ONE_SHOT_REPEAT_TIMER_TABLE_MACROS_SVH
`define ONE_SHOT_REPEAT_TIMER_TABLE_MACROS_SVH
// implication checked every clock outside reset
`define OSRT_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("osrt check failed");
// next-cycle implication
`define OSRT_ASSERT_NXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("osrt check failed");
`endif

[design/osrt_pkg.sv]
// shared types and codes of the timer table
package osrt_pkg;
  localparam logic [2:0] REQ_ONCE    = 3'd0;
  localparam logic [2:0] REQ_REPEAT  = 3'd1;
  localparam logic [2:0] REQ_CANCEL  = 3'd2;
  localparam logic [2:0] REQ_PAUSE   = 3'd3;
  localparam logic [2:0] REQ_RESUME  = 3'd4;
  localparam logic [2:0] REQ_ADVANCE = 3'd5;
  localparam logic [1:0] KIND_REPLY = 2'd0;
  localparam logic [1:0] KIND_FIRED = 2'd1;
  localparam logic [1:0] KIND_IDLE  = 2'd2;
  localparam logic [0:0] CFG_RUNNING = 1'd0;
  localparam logic [0:0] CFG_SCALE   = 1'd1;
  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] duration;
    logic [31:0] owner_handle;
    logic [31:0] creator_handle;
    logic [31:0] target_id;
    logic [31:0] delta_ticks;
  } in_item_t;
  typedef struct packed {
    logic [1:0]  kind;
    logic        ok;
    logic [31:0] timer_id;
    logic [31:0] owner_out;
    logic        last;
  } out_item_t;
endpackage

[design/one_shot_repeat_timer_table.sv]
// timer table: create, cancel, pause, resume and advance over a slot table
// cancel, pause, resume search slot by slot up to the hit or the first empty slot; cancel
//   then shifts each later slot down by one
// advance: multiply and saturate the scaled delta, walk the slots, fire (output may stall),
//   run catch-up steps, drop a one-shot by shifting, then finish; one 34-bit adder
// one item at a time: in_ready is low from accept until the cycle after the last result
// synchronous active-low reset empties the table, next id 1, running 1, scale 256
module one_shot_repeat_timer_table #(
  parameter int NUM_TIMERS   = 8,
  parameter int MAX_CATCH_UP = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  osrt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output osrt_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import osrt_pkg::*;

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(NUM_TIMERS + 1);
  localparam int FW = $clog2(MAX_CATCH_UP + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SEARCH, S_ACT, S_SHIFT, S_MUL, S_SAT, S_WALK, S_FIRE,
    S_CATCH, S_DONE, S_OUT, S_POST
  } state_t;

  state_t state_r;
  in_item_t req_r;
  logic running_r;
  logic [15:0] scale_r;
  logic [NUM_TIMERS-1:0] vld_r;
  logic [31:0] id_r [NUM_TIMERS];
  logic [31:0] own_r [NUM_TIMERS];
  logic [31:0] cre_r [NUM_TIMERS];
  logic signed [33:0] rem_r [NUM_TIMERS];
  logic [31:0] ivl_r [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] rep_r, pau_r;
  logic [31:0] next_id_r;
  logic [CW-1:0] cnt_r;
  logic [IW-1:0] idx_r, sh_r;
  logic [FW-1:0] fires_r;
  logic any_r;
  logic [31:0] pend_id_r, pend_own_r;
  logic [47:0] prod_r;
  logic [31:0] scaled_r;
  out_item_t out_r;

  // shared adder
  logic signed [33:0] add_a, add_b, add_y;
  assign add_y = add_a + add_b;
  always_comb begin
    add_a = rem_r[idx_r];
    add_b = (state_r == S_WALK) ? -$signed({2'b00, scaled_r})
                                : $signed({2'b00, ivl_r[idx_r]});
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      running_r <= 1'b1;
      scale_r <= 16'd256;
      vld_r <= '0;
      next_id_r <= 32'd1;
      cnt_r <= '0;
      any_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RUNNING: running_r <= cfg_wdata[0];
          CFG_SCALE:   scale_r <= cfg_wdata;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          req_r <= in_data;
          idx_r <= '0;
          any_r <= 1'b0;
          unique case (in_data.req_type) inside
            REQ_ONCE, REQ_REPEAT: state_r <= S_ACT;
            REQ_CANCEL, REQ_PAUSE, REQ_RESUME: state_r <= S_SEARCH;
            REQ_ADVANCE: state_r <= S_MUL;
            default: begin
              out_r <= '{KIND_REPLY, 1'b0, 32'd0, 32'd0, 1'b1};
              state_r <= S_OUT;
            end
          endcase
        end
        S_SEARCH: begin
          if (vld_r[idx_r] && id_r[idx_r] == req_r.target_id) begin
            out_r <= '{KIND_REPLY, 1'b1, 32'd0, 32'd0, 1'b1};
            if (req_r.req_type == REQ_CANCEL) begin
              sh_r <= idx_r;
              state_r <= S_SHIFT;
            end else begin
              pau_r[idx_r] <= (req_r.req_type == REQ_PAUSE);
              state_r <= S_OUT;
            end
          end else if (!vld_r[idx_r] || idx_r == IW'(NUM_TIMERS - 1)) begin
            out_r <= '{KIND_REPLY, 1'b0, 32'd0, 32'd0, 1'b1};
            state_r <= S_OUT;
          end else idx_r <= idx_r + 1'b1;
        end
        S_ACT: begin
          if (req_r.duration == 32'd0 || cnt_r == CW'(NUM_TIMERS)) begin
            out_r <= '{KIND_REPLY, 1'b0, 32'd0, 32'd0, 1'b1};
          end else begin
            vld_r[cnt_r[IW-1:0]] <= 1'b1;
            id_r[cnt_r[IW-1:0]] <= next_id_r;
            own_r[cnt_r[IW-1:0]] <= req_r.owner_handle;
            cre_r[cnt_r[IW-1:0]] <= req_r.creator_handle;
            rem_r[cnt_r[IW-1:0]] <= $signed({2'b00, req_r.duration});
            ivl_r[cnt_r[IW-1:0]] <= (req_r.req_type == REQ_REPEAT) ? req_r.duration : 32'd0;
            rep_r[cnt_r[IW-1:0]] <= (req_r.req_type == REQ_REPEAT);
            pau_r[cnt_r[IW-1:0]] <= 1'b0;
            cnt_r <= cnt_r + 1'b1;
            next_id_r <= (next_id_r == 32'hFFFF_FFFF) ? 32'd1 : next_id_r + 32'd1;
            out_r <= '{KIND_REPLY, 1'b1, next_id_r, 32'd0, 1'b1};
          end
          state_r <= S_OUT;
        end
        S_SHIFT: begin
          // move one slot down per cycle
          if (sh_r == IW'(NUM_TIMERS - 1)) begin
            vld_r[sh_r] <= 1'b0;
            cnt_r <= cnt_r - 1'b1;
            state_r <= (req_r.req_type == REQ_ADVANCE) ? S_WALK : S_OUT;
          end else begin
            vld_r[sh_r] <= vld_r[sh_r + 1'b1];
            id_r[sh_r]  <= id_r[sh_r + 1'b1];
            own_r[sh_r] <= own_r[sh_r + 1'b1];
            cre_r[sh_r] <= cre_r[sh_r + 1'b1];
            rem_r[sh_r] <= rem_r[sh_r + 1'b1];
            ivl_r[sh_r] <= ivl_r[sh_r + 1'b1];
            rep_r[sh_r] <= rep_r[sh_r + 1'b1];
            pau_r[sh_r] <= pau_r[sh_r + 1'b1];
            sh_r <= sh_r + 1'b1;
          end
        end
        S_MUL: begin
          prod_r <= 48'(req_r.delta_ticks) * 48'(running_r ? scale_r : 16'd0);
          state_r <= S_SAT;
        end
        S_SAT: begin
          scaled_r <= (prod_r[47:40] != 8'd0) ? 32'hFFFF_FFFF : prod_r[39:8];
          state_r <= S_WALK;
        end
        S_WALK: begin
          if (!vld_r[idx_r]) state_r <= S_DONE;
          else begin
            if (!pau_r[idx_r]) rem_r[idx_r] <= add_y;
            if (!pau_r[idx_r] && add_y <= 0) begin
              fires_r <= FW'(1);
              state_r <= S_FIRE;
            end else if (idx_r == IW'(NUM_TIMERS - 1)) state_r <= S_DONE;
            else idx_r <= idx_r + 1'b1;
          end
        end
        S_FIRE: begin
          // hold the newest fire back so the final one can carry last
          pend_id_r <= id_r[idx_r];
          pend_own_r <= own_r[idx_r];
          any_r <= 1'b1;
          if (any_r) begin
            out_r <= '{KIND_FIRED, 1'b1, pend_id_r, pend_own_r, 1'b0};
            state_r <= S_OUT;
          end else state_r <= S_POST;
        end
        S_POST: begin
          if (!rep_r[idx_r]) begin
            // one-shot leaves the table; walk resumes at the same slot
            sh_r <= idx_r;
            state_r <= S_SHIFT;
          end else state_r <= S_CATCH;
        end
        S_CATCH: begin
          if (fires_r < FW'(MAX_CATCH_UP)) begin
            rem_r[idx_r] <= add_y;
            fires_r <= fires_r + 1'b1;
            if (add_y <= 0) state_r <= S_FIRE;
            else if (idx_r == IW'(NUM_TIMERS - 1)) state_r <= S_DONE;
            else begin idx_r <= idx_r + 1'b1; state_r <= S_WALK; end
          end else begin
            if (rem_r[idx_r] <= 0) rem_r[idx_r] <= $signed({2'b00, ivl_r[idx_r]});
            if (idx_r == IW'(NUM_TIMERS - 1)) state_r <= S_DONE;
            else begin idx_r <= idx_r + 1'b1; state_r <= S_WALK; end
          end
        end
        S_DONE: begin
          if (!any_r) out_r <= '{KIND_IDLE, 1'b1, 32'd0, 32'd0, 1'b1};
          else out_r <= '{KIND_FIRED, 1'b1, pend_id_r, pend_own_r, 1'b1};
          state_r <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          if (out_r.last) state_r <= S_IDLE;
          else state_r <= S_POST;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

[design/osrt_checker.sv]
// port-level checker for the timer table, bound to the top level
`include "one_shot_repeat_timer_table_macros.svh"
module osrt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input osrt_pkg::out_item_t out_data,
  input logic                out_valid,
  input logic                out_ready
);
  import osrt_pkg::*;
  `OSRT_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `OSRT_ASSERT_IMP(a_no_ready_with_out, out_valid, !in_ready)
  `OSRT_ASSERT_IMP(a_fired_not_last_ok, out_valid && out_data.kind == KIND_FIRED, out_data.ok)
  `OSRT_ASSERT_NXT(a_out_holds, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule

bind one_shot_repeat_timer_table osrt_checker u_osrt_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
);

[bench/testbench.sv]
// self-checking testbench for the one-shot and repeating timer table
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import osrt_pkg::*;

  localparam int SLOTS = 8;
  localparam int CATCH_UP = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = CFG_RUNNING;
  logic [15:0] cfg_wdata = '0;

  one_shot_repeat_timer_table u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mirror of the timer table
  bit          tm_valid[SLOTS];
  bit [31:0]   tm_id[SLOTS];
  bit [31:0]   tm_owner[SLOTS];
  longint      tm_left[SLOTS];
  bit [31:0]   tm_period[SLOTS];
  bit          tm_rep[SLOTS];
  bit          tm_hold[SLOTS];
  bit [31:0]   id_next = 1;
  bit          play = 1'b1;
  bit [15:0]   scale = 16'd256;

  in_item_t  pending_q[$];
  out_item_t timer_events_q[$];
  int errors = 0;
  int n_results = 0;
  int n_fired = 0;
  int n_queued_creates = 0;
  bit idle_on = 1'b1;
  int long_hold_req = 0;

  function automatic void drop_slot(int k);
    for (int j = k; j + 1 < SLOTS; j++) begin
      tm_valid[j] = tm_valid[j+1];
      tm_id[j] = tm_id[j+1];
      tm_owner[j] = tm_owner[j+1];
      tm_left[j] = tm_left[j+1];
      tm_period[j] = tm_period[j+1];
      tm_rep[j] = tm_rep[j+1];
      tm_hold[j] = tm_hold[j+1];
    end
    tm_valid[SLOTS-1] = 1'b0;
  endfunction

  function automatic void queue_item(in_item_t it);
    pending_q = {pending_q, it};
  endfunction

  function automatic void add_event(ref out_item_t res[$], input logic [1:0] kind,
                                    input logic ok, input logic [31:0] id,
                                    input logic [31:0] own);
    out_item_t r;
    r.kind = kind; r.ok = ok; r.timer_id = id; r.owner_out = own; r.last = 1'b0;
    res = {res, r};
  endfunction

  function automatic void predict_events(in_item_t it);
    out_item_t res[$];
    int n, k, i, fires, total;
    longint unsigned scaled;
    n = 0;
    while (n < SLOTS && tm_valid[n]) n++;
    k = -1;
    for (int j = SLOTS - 1; j >= 0; j--)
      if (tm_valid[j] && tm_id[j] == it.target_id) k = j;
    case (it.req_type)
      REQ_ONCE, REQ_REPEAT: begin
        if (it.duration == 0 || n >= SLOTS) begin
          add_event(res, KIND_REPLY, 1'b0, '0, '0);
        end else begin
          tm_valid[n] = 1'b1;
          tm_id[n] = id_next;
          tm_owner[n] = it.owner_handle;
          tm_left[n] = longint'(it.duration);
          tm_rep[n] = (it.req_type == REQ_REPEAT);
          tm_period[n] = tm_rep[n] ? it.duration : 32'd0;
          tm_hold[n] = 1'b0;
          add_event(res, KIND_REPLY, 1'b1, id_next, '0);
          id_next = id_next + 1;
          if (id_next == 0) id_next = 1;
        end
      end
      REQ_CANCEL, REQ_PAUSE, REQ_RESUME: begin
        if (k >= 0) begin
          if (it.req_type == REQ_CANCEL) drop_slot(k);
          else tm_hold[k] = (it.req_type == REQ_PAUSE);
        end
        add_event(res, KIND_REPLY, k >= 0, '0, '0);
      end
      REQ_ADVANCE: begin
        scaled = (longint'(it.delta_ticks) * (play ? longint'(scale) : 0)) >> 8;
        if (scaled > 64'hFFFF_FFFF) scaled = 64'hFFFF_FFFF;
        i = 0;
        total = 0;
        while (i < SLOTS && tm_valid[i]) begin
          if (!tm_hold[i]) tm_left[i] -= longint'(scaled);
          if (tm_left[i] > 0) begin
            i++;
            continue;
          end
          add_event(res, KIND_FIRED, 1'b1, tm_id[i], tm_owner[i]);
          total++;
          if (!tm_rep[i]) begin
            drop_slot(i);
            continue;
          end
          fires = 1;
          while (tm_left[i] <= 0 && fires < CATCH_UP) begin
            tm_left[i] += longint'(tm_period[i]);
            if (tm_left[i] <= 0) begin
              add_event(res, KIND_FIRED, 1'b1, tm_id[i], tm_owner[i]);
              total++;
            end
            fires++;
          end
          if (tm_left[i] <= 0) tm_left[i] = longint'(tm_period[i]);
          i++;
        end
        if (total == 0) add_event(res, KIND_IDLE, 1'b1, '0, '0);
      end
      default: add_event(res, KIND_REPLY, 1'b0, '0, '0);
    endcase
    res[res.size()-1].last = 1'b1;
    foreach (res[j]) timer_events_q = {timer_events_q, res[j]};
  endfunction

  // predictor and checker at the rising edge
  bit in_taken = 1'b0;
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_events(in_data);
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (out_data.kind == KIND_FIRED) n_fired++;
        if (timer_events_q.size() == 0) begin
          $display("%0t: unexpected result %p", $realtime, out_data);
          errors++;
        end else begin
          e = timer_events_q.pop_front();
          if (e.kind !== out_data.kind || e.ok !== out_data.ok ||
              e.timer_id !== out_data.timer_id || e.owner_out !== out_data.owner_out ||
              e.last !== out_data.last) begin
            $display("%0t: mismatch expected %p actual %p", $realtime, e, out_data);
            errors++;
          end
        end
      end
    end
  end

  // item driver
  int in_gap = 0;
  always @(negedge clk) begin
    logic nv;
    in_item_t nd;
    nv = in_valid;
    nd = in_data;
    if (in_taken) begin
      nv = 1'b0;
      in_taken = 1'b0;
    end
    if (!nv && rst_n) begin
      if (in_gap > 0) in_gap--;
      else if (pending_q.size() > 0) begin
        if (idle_on && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 12);
        else begin
          nv = 1'b1;
          nd = pending_q.pop_front();
        end
      end
    end
    in_valid <= nv;
    in_data <= nd;
  end

  // result receiver with stall bursts and one long hold-off
  int out_gap = 0;
  always @(negedge clk) begin
    if (long_hold_req > 0) begin
      out_gap = long_hold_req;
      long_hold_req = 0;
    end
    if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 6) == 0) begin
      out_gap = $urandom_range(1, 12) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n;
    end
  end

  function automatic in_item_t make_item(logic [2:0] rt, logic [31:0] dur,
                                         logic [31:0] tgt, logic [31:0] dlt);
    in_item_t it;
    it.req_type = rt;
    it.duration = dur;
    it.owner_handle = $urandom();
    it.creator_handle = $urandom();
    it.target_id = tgt;
    it.delta_ticks = dlt;
    if (rt == REQ_ONCE || rt == REQ_REPEAT) n_queued_creates++;
    return it;
  endfunction

  task automatic add_random(int n);
    int r;
    logic [31:0] v;
    for (int j = 0; j < n; j++) begin
      r = $urandom_range(0, 99);
      v = $urandom_range(1, n_queued_creates + 2);
      if (r < 22)
        queue_item(make_item(REQ_ONCE,
          ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 3000), v, $urandom()));
      else if (r < 40)
        queue_item(make_item(REQ_REPEAT,
          ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(1, 400), v, $urandom()));
      else if (r < 50)
        queue_item(make_item(REQ_CANCEL, $urandom(),
          ($urandom_range(0, 5) == 0) ? $urandom() : v, $urandom()));
      else if (r < 57)
        queue_item(make_item(REQ_PAUSE, $urandom(), v, $urandom()));
      else if (r < 64)
        queue_item(make_item(REQ_RESUME, $urandom(), v, $urandom()));
      else if (r < 96)
        queue_item(make_item(REQ_ADVANCE, $urandom(), v,
          ($urandom_range(0, 12) == 0) ? $urandom() : $urandom_range(0, 1500)));
      else
        queue_item(make_item(3'($urandom_range(6, 7)), $urandom(), $urandom(),
                             $urandom()));
    end
  endtask

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_valid || timer_events_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_RUNNING) play = val[0];
    else scale = val;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // directed part
    queue_item(make_item(REQ_ONCE, 32'd0, '0, '0));
    queue_item(make_item(REQ_ONCE, 32'hFFFF_FFFF, '0, '0));
    queue_item(make_item(REQ_REPEAT, 32'd1, '0, '0));
    queue_item(make_item(REQ_ONCE, 32'd100, '0, '0));
    queue_item(make_item(REQ_REPEAT, 32'd50, '0, '0));
    queue_item(make_item(REQ_PAUSE, '0, 32'd4, '0));
    queue_item(make_item(REQ_ADVANCE, '0, '0, 32'd0));
    queue_item(make_item(REQ_ADVANCE, '0, '0, 32'd30));
    queue_item(make_item(REQ_ADVANCE, '0, '0, 32'd1000));
    queue_item(make_item(REQ_RESUME, '0, 32'd4, '0));
    queue_item(make_item(REQ_PAUSE, '0, 32'hFFFF_FFFF, '0));
    queue_item(make_item(REQ_RESUME, '0, 32'd0, '0));
    queue_item(make_item(REQ_CANCEL, '0, 32'd77, '0));
    for (int j = 0; j < 6; j++) queue_item(make_item(REQ_REPEAT, 32'd10, '0, '0));
    queue_item(make_item(REQ_ONCE, 32'd5, '0, '0));
    queue_item(make_item(REQ_CANCEL, '0, 32'd2, '0));
    queue_item(make_item(3'd6, '1, '1, '1));
    queue_item(make_item(3'd7, '0, '0, '0));
    queue_item(make_item(REQ_ADVANCE, '0, '0, 32'hFFFF_FFFF));
    wait_drained();
    // frozen clock: advances fire nothing
    write_reg(CFG_RUNNING, 16'd0);
    queue_item(make_item(REQ_REPEAT, 32'd3, '0, '0));
    add_random(10);
    wait_drained();
    // fastest scale, receiver holds off while items keep coming
    write_reg(CFG_RUNNING, 16'd1);
    write_reg(CFG_SCALE, 16'hFFFF);
    long_hold_req = 300;
    add_random(30);
    wait_drained();
    write_reg(CFG_SCALE, 16'd0);
    add_random(10);
    wait_drained();
    write_reg(CFG_SCALE, 16'd256);
    add_random(30);
    wait_drained();
    write_reg(CFG_SCALE, 16'd77);
    idle_on = 1'b0;
    add_random(25);
    wait_drained();
    $display("covered %0d results, %0d timer fires, over running off/on and scales 0..ffff",
             n_results, n_fired);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #8ms;
    $display("timeout");
    $display("Test completed with failures");
    $finish;
  end
endmodule
